// ===== rtl/pip_pkg.sv =====
package pip_pkg;

    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd3;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic vld;
        logic is_edge;
    } pipe_ctl_t;

    typedef struct packed {
        logic busy;
        logic hit_vld;
        logic hit;
    } edge_stat_t;

endpackage

// ===== rtl/point_in_polygon_test_top.sv =====
// Channel   Direction  Carries
// s_        in         vertex write or point test (tuser selects)
// m_        out        one inside flag per point test
// cfg_      in         number of vertices in use
//
// A point test over n vertices reads the vertex memory once per cycle (n + 1 reads,
// none when the vertex count is zero), and the edge unit adds the steps of compare,
// multiply and product compare before the result is loaded.
// Reset is synchronous, active low, and sets the vertex count to three; vertices
// are undefined until written. A stalled result holds only the final step of the next test.
module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 24,
    localparam int TDATA_W     = ((pip_pkg::IDX_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // vertex_index, coord_x, coord_y, zero fill
    input  logic [TDATA_W-1:0]           s_tdata,
    // action
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // inside_res, zero fill
    output logic [7:0]                   m_tdata,
    input  logic                         cfg_wr_en,
    input  logic [pip_pkg::CNT_W-1:0]    cfg_wr_data
);

    localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NB  = $clog2(MAX_VERTICES + 1);
    localparam int CW  = (NB > pip_pkg::CNT_W) ? NB : pip_pkg::CNT_W;
    localparam int XW  = (AW > pip_pkg::IDX_W) ? AW : pip_pkg::IDX_W;
    localparam int VW  = 2 * COORD_WIDTH;
    localparam int X_LO = pip_pkg::IDX_W;
    localparam int Y_LO = pip_pkg::IDX_W + COORD_WIDTH;

    logic [pip_pkg::IDX_W-1:0]     in_idx;
    logic signed [COORD_WIDTH-1:0] in_x, in_y;
    logic [XW-1:0]                 idx_ext;
    logic                          accept, wr_en, rd_en, finish;
    logic [AW-1:0]                 rd_addr;
    logic [CW-1:0]                 n_eff;

    pip_pkg::state_t               state_reg, state_next;
    logic [pip_pkg::CNT_W-1:0]     count_reg;
    logic [CW-1:0]                 n_reg, rd_cnt_reg, rd_cnt_next;
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;
    logic [VW-1:0]                 mem [MAX_VERTICES];
    logic [VW-1:0]                 rd_data_reg, prev_reg;
    pip_pkg::pipe_ctl_t            p0_ctl_reg;
    logic                          parity_reg, m_valid_reg, m_inside_reg;
    pip_pkg::edge_stat_t           stat;

    assign in_idx  = s_tdata[pip_pkg::IDX_W-1:0];
    assign in_x    = s_tdata[X_LO +: COORD_WIDTH];
    assign in_y    = s_tdata[Y_LO +: COORD_WIDTH];
    assign idx_ext = XW'(in_idx);

    assign s_tready = (state_reg == pip_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_tuser == pip_pkg::ACT_WRITE)
                      && (32'(idx_ext) < MAX_VERTICES);

    always_comb begin
        if (CW'(count_reg) > CW'(MAX_VERTICES)) begin
            n_eff = CW'(MAX_VERTICES);
        end else begin
            n_eff = CW'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= pip_pkg::CNT_RESET;
        end else if (cfg_wr_en) begin
            count_reg <= cfg_wr_data;
        end
    end

    // The first read fetches the last vertex, which closes the polygon.
    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        rd_en       = 1'b0;
        rd_addr     = '0;
        finish      = 1'b0;
        unique case (state_reg)
            pip_pkg::ST_IDLE: begin
                rd_cnt_next = '0;
                if (accept && (s_tuser == pip_pkg::ACT_TEST)) begin
                    state_next = (n_eff == '0) ? pip_pkg::ST_DRAIN : pip_pkg::ST_RUN;
                end
            end
            pip_pkg::ST_RUN: begin
                rd_en       = 1'b1;
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == '0) begin
                    rd_addr = AW'(n_reg - 1'b1);
                end else begin
                    rd_addr = AW'(rd_cnt_reg - 1'b1);
                end
                if (rd_cnt_reg == n_reg) begin
                    state_next = pip_pkg::ST_DRAIN;
                end
            end
            pip_pkg::ST_DRAIN: begin
                if (!p0_ctl_reg.vld && !stat.busy && (!m_valid_reg || m_tready)) begin
                    finish     = 1'b1;
                    state_next = pip_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pip_pkg::ST_IDLE;
            rd_cnt_reg  <= '0;
            p0_ctl_reg  <= '0;
            parity_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            p0_ctl_reg.vld     <= rd_en;
            p0_ctl_reg.is_edge <= (rd_cnt_reg != '0);
            if (accept && (s_tuser == pip_pkg::ACT_TEST)) begin
                parity_reg <= 1'b0;
            end else if (stat.hit_vld && stat.hit) begin
                parity_reg <= !parity_reg;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == pip_pkg::ACT_TEST)) begin
            n_reg  <= n_eff;
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (finish) begin
            m_inside_reg <= parity_reg;
        end
        if (p0_ctl_reg.vld) begin
            prev_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx_ext[AW-1:0]] <= {in_y, in_x};
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    pip_edge_unit #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_vld  (p0_ctl_reg.vld && p0_ctl_reg.is_edge),
        .x1      (prev_reg[COORD_WIDTH-1:0]),
        .y1      (prev_reg[VW-1:COORD_WIDTH]),
        .x2      (rd_data_reg[COORD_WIDTH-1:0]),
        .y2      (rd_data_reg[VW-1:COORD_WIDTH]),
        .px      (px_reg),
        .py      (py_reg),
        .stat    (stat)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_inside_reg};

endmodule

// ===== rtl/pip_edge_unit.sv =====
module pip_edge_unit #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_vld,
    input  logic signed [COORD_WIDTH-1:0] x1,
    input  logic signed [COORD_WIDTH-1:0] y1,
    input  logic signed [COORD_WIDTH-1:0] x2,
    input  logic signed [COORD_WIDTH-1:0] y2,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    output pip_pkg::edge_stat_t           stat
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;

    logic signed [COORD_WIDTH-1:0] xa, ya, xb, yb, maxx;
    logic signed [DW-1:0]          dx_next, dy_next, ey_next, ex_next;
    logic                          reject_next, horiz_next;

    logic signed [DW-1:0]          dx_reg, dy_reg, ey_reg, ex_reg;
    logic                          reject_reg, horiz_reg, s1_vld_reg;
    logic signed [PW-1:0]          p_reg, q_reg;
    logic                          reject2_reg, horiz2_reg, s2_vld_reg;
    logic signed [PW-1:0]          p_next, q_next;

    // The edge is oriented so that its lower end comes first.
    always_comb begin
        if (y1 > y2) begin
            xa = x2;
            ya = y2;
            xb = x1;
            yb = y1;
        end else begin
            xa = x1;
            ya = y1;
            xb = x2;
            yb = y2;
        end
        maxx        = (x1 > x2) ? x1 : x2;
        reject_next = (px > maxx) || (py < ya) || (py > yb);
        horiz_next  = (ya == yb);
        dx_next     = DW'(px) - DW'(xa);
        dy_next     = DW'(yb) - DW'(ya);
        ey_next     = DW'(py) - DW'(ya);
        ex_next     = DW'(xb) - DW'(xa);
    end

    always_ff @(posedge aclk) begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        ey_reg     <= ey_next;
        ex_reg     <= ex_next;
        reject_reg <= reject_next;
        horiz_reg  <= horiz_next;
    end

    // Point left of the crossing: (px - xa) * (yb - ya) <= (py - ya) * (xb - xa).
    assign p_next = PW'(dx_reg) * PW'(dy_reg);
    assign q_next = PW'(ey_reg) * PW'(ex_reg);

    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        q_reg       <= q_next;
        reject2_reg <= reject_reg;
        horiz2_reg  <= horiz_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    assign stat.busy    = s1_vld_reg || s2_vld_reg;
    assign stat.hit_vld = s2_vld_reg;
    assign stat.hit     = !reject2_reg && (horiz2_reg || (p_reg <= q_reg));

endmodule
